// ===== hdl/assert_macros.svh =====
// assertion helpers for the deque block
// each macro expects clk and rst_n in the scope where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every clock edge out of reset
`define BD_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("bd assertion failed");

// antecedent implies consequent on the next edge
`define BD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bd assertion failed");

// antecedent implies consequent on the same edge
`define BD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bd assertion failed");

`endif

// ===== hdl/bd_pkg.sv =====
// ---------------------------------------------------------------------------
// bd_pkg
// types and codes shared by the deque cells and the deque core
// ---------------------------------------------------------------------------
`default_nettype none

package bd_pkg;

  typedef enum logic [2:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_PEEK_FRONT = 3'd4,
    FN_PEEK_BACK  = 3'd5,
    FN_PEEK_INDEX = 3'd6,
    FN_DELETE     = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RSVD      = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [31:0]        tm;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // per-cell move control for one cycle
  typedef struct packed {
    logic load_req;
    logic take_prev;
    logic take_next;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/bd_cell.sv =====
// ---------------------------------------------------------------------------
// bd_cell
// one slot of the deque: holds an entry, shifts it to or from its
// neighbors and flags a match against the incoming item
// ---------------------------------------------------------------------------
`default_nettype none

module bd_cell
  import bd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      hit_en,
  input  wire entry_t    cmp_entry,
  input  wire cell_ctl_t ctl,
  input  wire entry_t    prev_entry,
  input  wire entry_t    next_entry,
  input  wire entry_t    req_entry,
  input  wire logic      valid,
  input  wire logic      seen_in,
  output entry_t         entry_q,
  output logic           seen_out
);

  entry_t entry_r;
  entry_t entry_nxt;
  logic   hit_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.load_req) begin
      entry_nxt = req_entry;
    end else if (ctl.take_prev) begin
      entry_nxt = prev_entry;
    end else if (ctl.take_next) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (hit_en) begin
      hit_r <= (entry_r == cmp_entry);
    end
  end

  // inclusive prefix of matches from the front
  assign seen_out = seen_in | (hit_r & valid);
  assign entry_q  = entry_r;

endmodule

`default_nettype wire

// ===== hdl/bounded_deque_with_delete_core.sv =====
// ---------------------------------------------------------------------------
// bounded_deque_with_delete_core
// double-ended queue of up to DEPTH entries with search and delete
// ---------------------------------------------------------------------------
// Usage: drive in_func and the entry fields and raise start; the item is
// taken at a clock edge where start is high and busy is low. busy stays
// high for the one cycle in which the item is carried out.
// The result (out_status, data fields, out_occupancy) is raised with a
// one-cycle out_valid strobe at the edge after the accepting edge. The
// receiver cannot stall; each result must be captured on its strobe.
// A new item is not taken until the last one is carried out. The
// accepting edge registers the match flag of every cell against the
// item; in the exec state the front-to-back match prefix runs through
// the cell chain and entries move.
// Reset (rst_n low, synchronous) empties the queue and clears the
// handshake; slot contents are not cleared and are never read until
// written. A push into a full queue is dropped with status full.
// ---------------------------------------------------------------------------
`default_nettype none

module bounded_deque_with_delete_core
  import bd_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         in_func,
  input  wire logic signed [15:0] in_entry_x,
  input  wire logic signed [15:0] in_entry_y,
  input  wire logic [31:0]        in_entry_time,
  input  wire logic [3:0]         in_position,
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output logic signed [15:0]      out_out_x,
  output logic signed [15:0]      out_out_y,
  output logic [31:0]             out_out_time,
  output logic [4:0]              out_occupancy
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = CNT_W + 4;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  func_t              func_r;
  entry_t             req_r;
  logic [3:0]         pos_r;
  logic               out_valid_r;
  status_t            status_r, status_nxt;
  entry_t             data_r, data_nxt;
  logic [4:0]         occ_r;

  logic               accept;
  logic               exec;
  entry_t             in_entry;
  entry_t             cell_q [DEPTH];
  cell_ctl_t          ctl    [DEPTH];
  logic               valid  [DEPTH];
  logic               seen   [DEPTH+1];
  logic [CMP_W-1:0]   count_ext;
  logic [CMP_W-1:0]   pos_ext;
  logic [CMP_W-1:0]   rd_idx;
  logic [ENTRY_W-1:0] rd_bits;
  logic [4:0]         occ_ext;
  logic               full;
  logic               empty;
  logic               found;

  assign accept    = start && !busy;
  assign exec      = (state_r == S_EXEC);
  assign busy      = exec;
  assign in_entry  = '{x: in_entry_x, y: in_entry_y, tm: in_entry_time};
  assign count_ext = CMP_W'(count_r);
  assign pos_ext   = CMP_W'(pos_r);
  assign full      = (count_ext >= CMP_W'(DEPTH));
  assign empty     = (count_r == '0);
  assign seen[0]   = 1'b0;
  assign found     = seen[DEPTH];

  always_comb begin
    unique case (state_r)
      S_IDLE:  state_nxt = accept ? S_EXEC : S_IDLE;
      S_EXEC:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // per-cell move control
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctl[i]   = '0;
      valid[i] = (CMP_W'(i) < count_ext);
      if (exec) begin
        unique case (func_r)
          FN_PUSH_FRONT: ctl[i].take_prev = !full;
          FN_PUSH_BACK:  ctl[i].load_req  = !full && (count_ext == CMP_W'(i));
          FN_POP_FRONT:  ctl[i].take_next = !empty;
          FN_DELETE:     ctl[i].take_next = seen[i+1];
          default:       ctl[i]           = '0;
        endcase
      end
    end
  end

  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    entry_t prev_e;
    entry_t next_e;
    if (gi == 0) begin : g_first
      assign prev_e = req_r;
    end else begin : g_mid
      assign prev_e = cell_q[gi-1];
    end
    if (gi == DEPTH - 1) begin : g_last
      assign next_e = cell_q[gi];
    end else begin : g_inner
      assign next_e = cell_q[gi+1];
    end

    bd_cell u_cell (
      .clk        (clk),
      .hit_en     (accept),
      .cmp_entry  (in_entry),
      .ctl        (ctl[gi]),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .req_entry  (req_r),
      .valid      (valid[gi]),
      .seen_in    (seen[gi]),
      .entry_q    (cell_q[gi]),
      .seen_out   (seen[gi+1])
    );
  end

  // read port: and-or select of one cell
  always_comb begin
    unique case (func_r) inside
      FN_POP_BACK, FN_PEEK_BACK: rd_idx = count_ext - CMP_W'(1);
      FN_PEEK_INDEX:             rd_idx = pos_ext;
      default:                   rd_idx = '0;
    endcase
    rd_bits = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (rd_idx == CMP_W'(i)) begin
        rd_bits = rd_bits | cell_q[i];
      end
    end
  end

  always_comb begin
    status_nxt = ST_DONE;
    data_nxt   = '0;
    count_nxt  = count_r;
    if (exec) begin
      unique case (func_r) inside
        FN_PUSH_FRONT, FN_PUSH_BACK: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
        FN_POP_FRONT, FN_POP_BACK: begin
          if (empty) begin
            status_nxt = ST_NOT_FOUND;
          end else begin
            data_nxt  = entry_t'(rd_bits);
            count_nxt = count_r - CNT_W'(1);
          end
        end
        FN_PEEK_FRONT, FN_PEEK_BACK: begin
          if (empty) begin
            status_nxt = ST_NOT_FOUND;
          end else begin
            data_nxt = entry_t'(rd_bits);
          end
        end
        FN_PEEK_INDEX: begin
          if (pos_ext >= count_ext) begin
            status_nxt = ST_NOT_FOUND;
          end else begin
            data_nxt = entry_t'(rd_bits);
          end
        end
        default: begin
          if (found) begin
            count_nxt = count_r - CNT_W'(1);
          end else begin
            status_nxt = ST_NOT_FOUND;
          end
        end
      endcase
    end
  end

  // occupancy is the count modulo 32
  assign occ_ext = 5'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= exec;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= func_t'(in_func);
      req_r  <= in_entry;
      pos_r  <= in_position;
    end
    if (exec) begin
      status_r <= status_nxt;
      data_r   <= data_nxt;
      occ_r    <= occ_ext;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_out_x     = data_r.x;
  assign out_out_y     = data_r.y;
  assign out_out_time  = data_r.tm;
  assign out_occupancy = occ_r;

`include "assert_macros.svh"

  `BD_ASSERT_NEXT(a_accept_exec, accept, busy && !out_valid)
  `BD_ASSERT_NEXT(a_exec_result, exec, out_valid && !busy)
  `BD_ASSERT_ALWAYS(a_count_bound, count_ext <= CMP_W'(DEPTH))
  `BD_ASSERT_SAME(a_full_status, out_valid && (out_status == ST_FULL),
                  $past(count_ext) == CMP_W'(DEPTH))

endmodule

`default_nettype wire
